[src/multi_pattern_word_masker_defines.svh]
// ---------------------------------------------------------------------------
// multi_pattern_word_masker_defines.svh
// assertion macros shared by the word masker rtl; expects clk and arst_n
// in scope
// ---------------------------------------------------------------------------
`ifndef MULTI_PATTERN_WORD_MASKER_DEFINES_SVH
`define MULTI_PATTERN_WORD_MASKER_DEFINES_SVH

`ifndef SYNTHESIS

// property that holds in the same cycle, disabled in reset
`define MPWM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// antecedent in one cycle implies consequent in the next
`define MPWM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define MPWM_ASSERT(lbl, prop, msg)
`define MPWM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[src/mpwm_pkg.sv]
// ---------------------------------------------------------------------------
// mpwm_pkg
// shared types and constants of the multi pattern word masker
// ---------------------------------------------------------------------------
package mpwm_pkg;

	// sizes
	localparam int CHAR_W           = 8;
	localparam int PAT_BYTES        = 8;
	localparam int PAT_W            = CHAR_W * PAT_BYTES;
	localparam int LEN_W            = 4;
	localparam int MAX_PATTERNS     = 3;
	localparam int SLOT_W           = $clog2(MAX_PATTERNS);
	localparam int CFG_IDX_W        = 3;
	localparam int MAX_LEN_DEF      = 8;
	localparam int NUM_PATTERNS_DEF = 3;

	// replacement byte for masked positions
	localparam logic [CHAR_W-1:0] MASK_CHAR = 8'd42;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_A     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_A_LEN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_B     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_B_LEN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_C     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_C_LEN = 3'd5;

	// reset words: "fuck", "sb", "bitch", byte zero in the low bits
	localparam logic [PAT_W-1:0] PAT_RESET [MAX_PATTERNS] = '{
		64'd1801680230, 64'd25203, 64'd448345172322
	};
	localparam logic [LEN_W-1:0] LEN_RESET [MAX_PATTERNS] = '{4'd4, 4'd2, 4'd5};

	// one byte on a link between stages
	typedef struct packed {
		logic              valid;
		logic [CHAR_W-1:0] ch;
		logic              last;
	} mpwm_item_t;

endpackage

[src/mpwm_stage.sv]
// ---------------------------------------------------------------------------
// mpwm_stage
// one masking stage: holds a window of message bytes, masks the leftmost
// non-overlapping matches of its pattern and drains the window on the last
// byte of a message
// ---------------------------------------------------------------------------
`include "multi_pattern_word_masker_defines.svh"

module mpwm_stage
	import mpwm_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  mpwm_item_t         in,
	input  logic [PAT_W-1:0]   pattern,
	input  logic [LEN_W-1:0]   pattern_len,
	output mpwm_item_t         out,
	output logic               done
);

	localparam int HOLD_W = $clog2(MAX_LEN);
	localparam int FILL_W = $clog2(MAX_LEN + 1);
	localparam int CMP_N  = (MAX_LEN < PAT_BYTES) ? MAX_LEN : PAT_BYTES;

	// held window, oldest byte first
	logic [CHAR_W-1:0] win_q [MAX_LEN-1];
	logic [HOLD_W-1:0] fill_q;
	logic              drain_q;
	logic [LEN_W-1:0]  mask_q;

	logic              out_valid_q;
	logic [CHAR_W-1:0] out_ch_q;
	logic              out_last_q;

	logic [CHAR_W-1:0] eff [MAX_LEN];
	logic [CHAR_W-1:0] win_nx [MAX_LEN-1];
	logic [FILL_W-1:0] eff_fill;
	logic              drain_nx;
	logic              emit;
	logic              emit_last;
	logic              len_ok;
	logic              match;
	logic [LEN_W-1:0]  mask_eff;
	logic              masked;
	logic [LEN_W-1:0]  mask_nx;

	// window with the incoming byte appended
	always_comb begin
		for (int i = 0; i < MAX_LEN - 1; i++) begin
			eff[i] = (in.valid && (fill_q == HOLD_W'(i))) ? in.ch : win_q[i];
		end
		eff[MAX_LEN-1] = in.ch;
	end

	assign eff_fill  = FILL_W'(fill_q) + FILL_W'(in.valid);
	assign drain_nx  = drain_q || (in.valid && in.last);
	assign emit      = (eff_fill == FILL_W'(MAX_LEN)) || (drain_nx && (eff_fill != '0));
	assign emit_last = emit && drain_nx && (eff_fill == FILL_W'(1));

	// pattern compare at the head of the window
	assign len_ok = (pattern_len != '0) && (int'(pattern_len) <= PAT_BYTES)
		&& (int'(pattern_len) <= MAX_LEN);

	always_comb begin
		match = len_ok && (int'(eff_fill) >= int'(pattern_len));
		for (int i = 0; i < CMP_N; i++) begin
			if ((i < int'(pattern_len)) && (eff[i] != pattern[CHAR_W*i +: CHAR_W])) begin
				match = 1'b0;
			end
		end
	end

	// mask run bookkeeping
	assign mask_eff = ((mask_q == '0) && match) ? pattern_len : mask_q;
	assign masked   = (mask_eff != '0);

	always_comb begin
		if (emit_last) begin
			mask_nx = '0;
		end else if (masked) begin
			mask_nx = mask_eff - LEN_W'(1);
		end else begin
			mask_nx = mask_eff;
		end
	end

	// shift out the oldest byte when emitting
	always_comb begin
		for (int i = 0; i < MAX_LEN - 1; i++) begin
			win_nx[i] = emit ? eff[i+1] : eff[i];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			drain_q     <= 1'b0;
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			fill_q      <= HOLD_W'(eff_fill - FILL_W'(emit));
			drain_q     <= drain_nx && !emit_last;
			out_valid_q <= emit;
			if (emit) begin
				mask_q <= mask_nx;
			end
		end
	end

	// window and result payload
	always_ff @(posedge clk) begin
		if (en) begin
			win_q <= win_nx;
			if (emit) begin
				out_ch_q   <= masked ? MASK_CHAR : eff[0];
				out_last_q <= emit_last;
			end
		end
	end

	assign out  = '{valid: out_valid_q, ch: out_ch_q, last: out_last_q};
	assign done = en && emit_last;

	// checks
	`MPWM_ASSERT_NEXT(a_drain_empties, en && emit_last, (fill_q == '0) && (mask_q == '0) && !drain_q, "stage not empty after last transfer")
	`MPWM_ASSERT(a_no_push_in_drain, !(en && drain_q && in.valid), "byte pushed into a draining stage")
	`MPWM_ASSERT_NEXT(a_emit_visible, en && emit, out_valid_q, "emitted byte not registered")

endmodule

[src/multi_pattern_word_masker.sv]
// ---------------------------------------------------------------------------
// multi_pattern_word_masker
// replaces leftmost non-overlapping matches of up to three banned words in a
// byte stream with '*', one masking stage per word, chained in register order
// ---------------------------------------------------------------------------
// usage
// - input channel in_valid/in_stall carries in_char and in_last; a transfer
//   happens when in_valid is high and in_stall is low
// - output channel out_valid/out_stall carries out_char and out_last, the
//   same bytes in the same order with banned words masked
// - each stage holds MAX_LEN-1 bytes, so a byte reaches the output after the
//   transfer of the byte that came NUM_PATTERNS*(MAX_LEN-1) places after it
//   and its passage through one output register per stage
// - within a message one byte per cycle is taken while the output does not
//   stall; after the last byte the input stalls while the stages drain one
//   byte per cycle each, unless the output stalls, until the final byte of
//   the message reaches the output register
// - a stall on the output with out_valid high freezes every stage; in_stall
//   follows in the same cycle
// - reset empties all stages and loads the default words; unchecked, the user
//   writes pattern registers via cfg_wr_en/cfg_index/cfg_data while idle
// ---------------------------------------------------------------------------
`include "multi_pattern_word_masker_defines.svh"

module multi_pattern_word_masker
	import mpwm_pkg::*;
#(
	parameter int MAX_LEN      = MAX_LEN_DEF,
	parameter int NUM_PATTERNS = NUM_PATTERNS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [CHAR_W-1:0]    in_char,
	input  logic                 in_last,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CHAR_W-1:0]    out_char,
	output logic                 out_last,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PAT_W-1:0]     cfg_data
);

	logic [PAT_W-1:0]        pat_q [NUM_PATTERNS];
	logic [LEN_W-1:0]        len_q [NUM_PATTERNS];
	logic                    flush_q;

	logic                    wr_hit;
	logic                    wr_len;
	logic [SLOT_W-1:0]       wr_slot;
	logic                    en;
	logic                    accept;
	mpwm_item_t              link [NUM_PATTERNS+1];
	logic [NUM_PATTERNS-1:0] stage_done;

	// register index decode
	always_comb begin
		wr_hit  = 1'b1;
		wr_len  = 1'b0;
		wr_slot = '0;
		unique case (cfg_index)
			REG_PATTERN_A: begin
				wr_slot = SLOT_W'(0);
			end
			REG_PATTERN_A_LEN: begin
				wr_slot = SLOT_W'(0);
				wr_len  = 1'b1;
			end
			REG_PATTERN_B: begin
				wr_slot = SLOT_W'(1);
			end
			REG_PATTERN_B_LEN: begin
				wr_slot = SLOT_W'(1);
				wr_len  = 1'b1;
			end
			REG_PATTERN_C: begin
				wr_slot = SLOT_W'(2);
			end
			REG_PATTERN_C_LEN: begin
				wr_slot = SLOT_W'(2);
				wr_len  = 1'b1;
			end
			default: begin
				wr_hit = 1'b0;
			end
		endcase
	end

	// pattern registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_PATTERNS; s++) begin
				pat_q[s] <= PAT_RESET[s];
				len_q[s] <= LEN_RESET[s];
			end
		end else if (cfg_wr_en && wr_hit) begin
			for (int s = 0; s < NUM_PATTERNS; s++) begin
				if (wr_slot == SLOT_W'(s)) begin
					if (wr_len) begin
						len_q[s] <= cfg_data[LEN_W-1:0];
					end else begin
						pat_q[s] <= cfg_data;
					end
				end
			end
		end
	end

	// chain advances whenever the output register is free or being emptied
	assign en       = !link[NUM_PATTERNS].valid || !out_stall;
	assign in_stall = !en || flush_q;
	assign accept   = in_valid && !in_stall;

	// message flush in progress: from last byte in until it reaches the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_q <= 1'b0;
		end else if (accept && in_last) begin
			flush_q <= 1'b1;
		end else if (stage_done[NUM_PATTERNS-1]) begin
			flush_q <= 1'b0;
		end
	end

	assign link[0] = '{valid: accept, ch: in_char, last: in_last};

	// one masking stage per pattern
	for (genvar s = 0; s < NUM_PATTERNS; s++) begin : g_stage
		mpwm_stage #(
			.MAX_LEN(MAX_LEN)
		) u_stage (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.in         (link[s]),
			.pattern    (pat_q[s]),
			.pattern_len(len_q[s]),
			.out        (link[s+1]),
			.done       (stage_done[s])
		);
	end

	assign out_valid = link[NUM_PATTERNS].valid;
	assign out_char  = link[NUM_PATTERNS].ch;
	assign out_last  = link[NUM_PATTERNS].last;

	// checks
	`MPWM_ASSERT_NEXT(a_last_blocks_input, in_valid && in_last && !in_stall, in_stall, "input taken during message flush")

endmodule
